// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, cond, conseq) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("%m: assertion failed");

`endif

// ===== design/egcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package egcd_pkg;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;      // capture operands from the request transaction
      logic strip;     // remove one common factor of two
      logic step;      // one reduction step: halve, or subtract with or without a swap
      logic out_load;  // move the result into the response register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic strip_ok;  // both remainders even and first operand nonzero
      logic r1_zero;   // second remainder has reached zero
   } status_type;

endpackage

`default_nettype wire

// ===== design/egcd_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface egcd_req_if #(parameter int WIDTH = 32);
   logic               valid;
   logic               ready;
   logic [WIDTH-2:0]   operand_a;
   logic [WIDTH-2:0]   operand_b;

   modport source (output valid, output operand_a, output operand_b, input ready);
   modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

`default_nettype wire

// ===== design/egcd_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface egcd_rsp_if #(parameter int WIDTH = 32);
   logic                      valid;
   logic                      ready;
   logic        [WIDTH-2:0]   divisor;
   logic signed [WIDTH-1:0]   coef_a;
   logic signed [WIDTH-1:0]   coef_b;

   modport source (output valid, output divisor, output coef_a, output coef_b, input ready);
   modport sink   (input valid, input divisor, input coef_a, input coef_b, output ready);
endinterface

`default_nettype wire

// ===== design/egcd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module egcd_ctrl
   import egcd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output      cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STRIP,
      ST_REDUCE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_STRIP;
            end
         end
         ST_STRIP: begin
            if (status.strip_ok) begin
               cmd.strip = 1'b1;
            end else begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (status.r1_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_FINISH: begin
            // hold the result until the response register is free
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/egcd_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module egcd_dpath
   import egcd_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire cmd_type                  cmd,
   output      status_type               status,
   input  wire logic        [WIDTH-2:0]  operand_a,
   input  wire logic        [WIDTH-2:0]  operand_b,
   output      logic        [WIDTH-2:0]  divisor,
   output      logic signed [WIDTH-1:0]  coef_a,
   output      logic signed [WIDTH-1:0]  coef_b
);

   localparam int OW = WIDTH - 1;      // operand width
   localparam int CW = WIDTH + 2;      // coefficient width with headroom
   localparam int TW = $clog2(WIDTH);  // width of the count of common factors of two

   logic        [OW-1:0] r0_ff, r0_in, r1_ff, r1_in;
   logic        [OW-1:0] ra_ff, ra_in, rb_ff, rb_in;
   logic signed [CW-1:0] s0_ff, s0_in, t0_ff, t0_in;
   logic signed [CW-1:0] s1_ff, s1_in, t1_ff, t1_in;
   logic        [TW-1:0] twos_ff, twos_in;
   logic                 a_zero_ff, a_zero_in;
   logic        [OW-1:0] divisor_ff, divisor_in;
   logic signed [WIDTH-1:0] coef_a_ff, coef_a_in, coef_b_ff, coef_b_in;

   logic                 a_is_zero;
   logic signed [CW-1:0] hc, hd, hc_sum, hd_sum, hc_half, hd_half;
   logic signed [CW-1:0] ra_ext, rb_ext;

   assign a_is_zero = (operand_a == '0);
   assign ra_ext    = $signed({{(CW-OW){1'b0}}, ra_ff});
   assign rb_ext    = $signed({{(CW-OW){1'b0}}, rb_ff});

   // Shared halver: serves the first pair while r0 is even, else the second
   always_comb begin
      hc = r0_ff[0] ? s1_ff : s0_ff;
      hd = r0_ff[0] ? t1_ff : t0_ff;
      if (!hc[0] && !hd[0]) begin
         hc_sum = hc;
         hd_sum = hd;
      end else begin
         hc_sum = hc + rb_ext;
         hd_sum = hd - ra_ext;
      end
      hc_half = {hc_sum[CW-1], hc_sum[CW-1:1]};
      hd_half = {hd_sum[CW-1], hd_sum[CW-1:1]};
   end

   always_comb begin
      r0_in      = r0_ff;
      r1_in      = r1_ff;
      ra_in      = ra_ff;
      rb_in      = rb_ff;
      s0_in      = s0_ff;
      t0_in      = t0_ff;
      s1_in      = s1_ff;
      t1_in      = t1_ff;
      twos_in    = twos_ff;
      a_zero_in  = a_zero_ff;
      divisor_in = divisor_ff;
      coef_a_in  = coef_a_ff;
      coef_b_in  = coef_b_ff;
      priority if (cmd.load) begin
         r0_in     = a_is_zero ? operand_b : operand_a;
         r1_in     = a_is_zero ? '0 : operand_b;
         ra_in     = r0_in;
         rb_in     = r1_in;
         s0_in     = a_is_zero ? CW'(0) : CW'(1);
         t0_in     = a_is_zero ? CW'(1) : CW'(0);
         s1_in     = CW'(0);
         t1_in     = CW'(1);
         twos_in   = '0;
         a_zero_in = a_is_zero;
      end else if (cmd.strip) begin
         // ra and rb follow the remainders until the strip ends
         r0_in   = r0_ff >> 1;
         r1_in   = r1_ff >> 1;
         ra_in   = r0_in;
         rb_in   = r1_in;
         twos_in = twos_ff + TW'(1);
      end else if (cmd.step) begin
         priority if (!r0_ff[0]) begin
            r0_in = r0_ff >> 1;
            s0_in = hc_half;
            t0_in = hd_half;
         end else if (!r1_ff[0]) begin
            r1_in = r1_ff >> 1;
            s1_in = hc_half;
            t1_in = hd_half;
         end else if (r1_ff < r0_ff) begin
            // swap and subtract in one go
            r0_in = r1_ff;
            s0_in = s1_ff;
            t0_in = t1_ff;
            r1_in = r0_ff - r1_ff;
            s1_in = s0_ff - s1_ff;
            t1_in = t0_ff - t1_ff;
         end else begin
            r1_in = r1_ff - r0_ff;
            s1_in = s1_ff - s0_ff;
            t1_in = t1_ff - t0_ff;
         end
      end else if (cmd.out_load) begin
         divisor_in = r0_ff << twos_ff;
         coef_a_in  = s0_ff[WIDTH-1:0];
         coef_b_in  = t0_ff[WIDTH-1:0];
      end else begin
         r0_in = r0_ff;
      end
   end

   always_ff @(posedge clock) begin
      r0_ff      <= r0_in;
      r1_ff      <= r1_in;
      ra_ff      <= ra_in;
      rb_ff      <= rb_in;
      s0_ff      <= s0_in;
      t0_ff      <= t0_in;
      s1_ff      <= s1_in;
      t1_ff      <= t1_in;
      twos_ff    <= twos_in;
      a_zero_ff  <= a_zero_in;
      divisor_ff <= divisor_in;
      coef_a_ff  <= coef_a_in;
      coef_b_ff  <= coef_b_in;
   end

   assign status.strip_ok = !r0_ff[0] && !r1_ff[0] && !a_zero_ff;
   assign status.r1_zero  = (r1_ff == '0);

   assign divisor = divisor_ff;
   assign coef_a  = coef_a_ff;
   assign coef_b  = coef_b_ff;

endmodule

`default_nettype wire

// ===== design/extended_binary_gcd_top.sv =====
// Channel    Role    Payload
// req_chan   sink    operand_a, operand_b (WIDTH-1 bits, unsigned)
// rsp_chan   source  divisor (WIDTH-1 bits), coef_a, coef_b (WIDTH bits, signed)
//
// A transaction loads the operands, strips their common factors of two, then runs
// the reduction steps of the halve / subtract loop and moves the result out.
// The reduction loop does one halving or one subtraction per cycle.
// Synchronous reset returns the controller to idle and drops any pending response.
// A new request is taken while a response still waits; a finished result holds
// until the response register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module extended_binary_gcd_top
   import egcd_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input wire logic    clock,
   input wire logic    reset,
   egcd_req_if.sink    req_chan,
   egcd_rsp_if.source  rsp_chan
);

   cmd_type    cmd;
   status_type status;
   logic       rsp_valid;

   egcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   egcd_dpath #(
      .WIDTH (WIDTH)
   ) u_dpath (
      .clock     (clock),
      .cmd       (cmd),
      .status    (status),
      .operand_a (req_chan.operand_a),
      .operand_b (req_chan.operand_b),
      .divisor   (rsp_chan.divisor),
      .coef_a    (rsp_chan.coef_a),
      .coef_b    (rsp_chan.coef_b)
   );

   assign rsp_chan.valid = rsp_valid;

   `ASSERT_CLK(chk_cmd_onehot, clock, reset, $onehot0({cmd.load, cmd.strip, cmd.step, cmd.out_load}))
   `ASSERT_CLK(chk_no_overwrite, clock, reset, cmd.out_load |-> (!rsp_valid || rsp_chan.ready))
   `ASSERT_CLK(chk_step_live, clock, reset, cmd.step |-> !status.r1_zero)
   `ASSERT_NEXT(chk_busy_after_accept, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)

endmodule

`default_nettype wire
